@@ src/diagonal_shift_image_scrambler_unit_defines.svh @@
// assertion helpers for the scrambler unit rtl
`ifndef DIAGONAL_SHIFT_IMAGE_SCRAMBLER_UNIT_DEFINES_SVH
`define DIAGONAL_SHIFT_IMAGE_SCRAMBLER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DSIS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsis assertion failed");

// next-cycle implication, checked out of reset
`define DSIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsis assertion failed");

`endif

@@ src/dsis_pkg.sv @@
package dsis_pkg;

  localparam int PIX_W   = 24;
  localparam int COORD_W = 9;   // coordinates after a move can reach frame size minus one
  localparam int DVD_W   = 10;  // row + col + shift fits here
  localparam int CNT_W   = 4;

  localparam logic [1:0] REG_PERM_INDEX   = 2'd0;
  localparam logic [1:0] REG_INVERT_MODE  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    MV_R = 2'd0,
    MV_L = 2'd1,
    MV_U = 2'd2,
    MV_D = 2'd3
  } move_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MOD,
    S_APPLY,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  localparam move_t MOVE_FIRST [8] = '{MV_R, MV_R, MV_L, MV_L, MV_U, MV_U, MV_D, MV_D};
  localparam move_t MOVE_SECOND [8] = '{MV_D, MV_U, MV_D, MV_U, MV_R, MV_L, MV_R, MV_L};

  // R<->L, U<->D
  function automatic move_t inv_move(input move_t m);
    return move_t'({m[1], ~m[0]});
  endfunction

endpackage

@@ src/diagonal_shift_image_scrambler_unit.sv @@
// writes are accepted back to back while the block is idle
// a read inside the frame runs two moves, each (setup, 10 remainder steps plus done,
// apply) on the shared remainder unit, then frame store read and result load; a read
// outside the frame skips the moves and goes straight to the result load
// no item is accepted while a read works or while its result waits for the output register
// rst_n is synchronous, active low: resets control and config registers, not the frame store
module diagonal_shift_image_scrambler_unit #(
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_WIDTH    = 256,
  parameter int CHANNELS     = 3,
  parameter int CHANNEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row [7:0], col [15:8], pixel_in [39:16]
  input  logic        in_tuser,   // cmd [0]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_out [23:0]
  output logic        out_tuser,  // out_of_range [0]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  `include "diagonal_shift_image_scrambler_unit_defines.svh"

  localparam int CW = dsis_pkg::COORD_W;
  localparam int DW = dsis_pkg::DVD_W;
  localparam int PW = dsis_pkg::PIX_W;

  // largest frame size reachable through the 9-bit size registers
  localparam int SIZE_CAP = (1 << CW) - 1;
  localparam int HCAP     = (MAX_HEIGHT < SIZE_CAP) ? MAX_HEIGHT : SIZE_CAP;
  localparam int WCAP     = (MAX_WIDTH < SIZE_CAP) ? MAX_WIDTH : SIZE_CAP;
  localparam int DEPTH    = HCAP * MAX_WIDTH;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // pixel bits kept on a write
  localparam int PIX_BITS = CHANNELS * CHANNEL_BITS;
  localparam int PB       = (PIX_BITS >= PW) ? PW : PIX_BITS;
  localparam logic [PW-1:0] PIX_MASK = PW'((33'd1 << PB) - 33'd1);

  // configuration registers
  logic [6:0]    perm_r;
  logic          inv_r;
  logic [CW-1:0] fh_r;
  logic [CW-1:0] fw_r;

  // sequencer and working coordinates
  dsis_pkg::state_t state_r, state_nxt;
  logic          step_r;
  logic          oor_r;
  logic [CW-1:0] r_r;
  logic [CW-1:0] c_r;

  // result register
  logic          out_valid_r;
  logic [PW-1:0] out_data_r;
  logic          out_oor_r;

  // frame store
  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rd_data_r;

  logic [7:0]    in_row;
  logic [7:0]    in_col;
  logic [PW-1:0] in_pix;
  logic          in_accept;
  logic          in_inside;
  logic [CW-1:0] h_eff;
  logic [CW-1:0] w_eff;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  dsis_pkg::move_t mv_a, mv_b, mv_cur;
  logic [1:0]    shift_n;
  logic [DW-1:0] mod_dividend;
  logic [CW-1:0] mod_divisor;
  logic          mod_start;
  dsis_pkg::mod_stat_t mod_stat;
  logic [CW-1:0] mod_rem;
  logic [CW-1:0] r_new;
  logic [CW-1:0] c_new;
  logic          resp_load;

  assign in_row = in_tdata[7:0];
  assign in_col = in_tdata[15:8];
  assign in_pix = in_tdata[39:16];

  // oversized frames saturate to the store size
  assign h_eff = (fh_r > CW'(HCAP)) ? CW'(HCAP) : fh_r;
  assign w_eff = (fw_r > CW'(WCAP)) ? CW'(WCAP) : fw_r;

  assign in_accept = in_tvalid && in_tready;
  assign in_inside = ({1'b0, in_row} < h_eff) && ({1'b0, in_col} < w_eff);
  assign wr_en     = in_accept && (in_tuser == dsis_pkg::CMD_WRITE) && in_inside;
  assign wr_addr   = AW'(AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col));
  assign rd_addr   = AW'(AW'(r_r) * AW'(MAX_WIDTH) + AW'(c_r));

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_r <= '0;
      inv_r  <= 1'b0;
      fh_r   <= 9'd256;
      fw_r   <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsis_pkg::REG_PERM_INDEX:   perm_r <= cfg_wdata[6:0];
        dsis_pkg::REG_INVERT_MODE:  inv_r  <= cfg_wdata[0];
        dsis_pkg::REG_FRAME_HEIGHT: fh_r   <= cfg_wdata;
        dsis_pkg::REG_FRAME_WIDTH:  fw_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // move undone in this step: forward undoes second then first,
  // inverse undoes inv(first) then inv(second)
  always_comb begin
    mv_a = dsis_pkg::MOVE_FIRST[perm_r[6:4]];
    mv_b = dsis_pkg::MOVE_SECOND[perm_r[6:4]];
    if (inv_r) begin
      mv_cur = step_r ? dsis_pkg::inv_move(mv_b) : dsis_pkg::inv_move(mv_a);
    end else begin
      mv_cur = step_r ? mv_a : mv_b;
    end
    // vertical moves take bits 3..2, horizontal ones bits 1..0
    shift_n = mv_cur[1] ? perm_r[3:2] : perm_r[1:0];
  end

  // operands for the shared remainder unit
  always_comb begin
    unique case (mv_cur)
      dsis_pkg::MV_R,
      dsis_pkg::MV_U: mod_dividend = DW'(r_r) + DW'(c_r) + DW'(shift_n);
      dsis_pkg::MV_L: mod_dividend = DW'(r_r) + DW'(shift_n);
      dsis_pkg::MV_D: mod_dividend = DW'(c_r) + DW'(shift_n);
      default:        mod_dividend = '0;
    endcase
    mod_divisor = mv_cur[1] ? h_eff : w_eff;
  end

  dsis_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  // fold the remainder back into the coordinate; L and D subtract it cyclically
  always_comb begin
    r_new = r_r;
    c_new = c_r;
    unique case (mv_cur)
      dsis_pkg::MV_R: c_new = mod_rem;
      dsis_pkg::MV_U: r_new = mod_rem;
      dsis_pkg::MV_L: c_new = (c_r >= mod_rem) ? CW'(c_r - mod_rem)
                            : CW'({1'b0, c_r} + {1'b0, w_eff} - {1'b0, mod_rem});
      dsis_pkg::MV_D: r_new = (r_r >= mod_rem) ? CW'(r_r - mod_rem)
                            : CW'({1'b0, r_r} + {1'b0, h_eff} - {1'b0, mod_rem});
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsis_pkg::S_IDLE: begin
        if (in_accept && (in_tuser == dsis_pkg::CMD_READ)) begin
          state_nxt = in_inside ? dsis_pkg::S_SETUP : dsis_pkg::S_RESP;
        end
      end
      dsis_pkg::S_SETUP: state_nxt = dsis_pkg::S_MOD;
      dsis_pkg::S_MOD: begin
        if (mod_stat.done) begin
          state_nxt = dsis_pkg::S_APPLY;
        end
      end
      dsis_pkg::S_APPLY: state_nxt = step_r ? dsis_pkg::S_READ : dsis_pkg::S_SETUP;
      dsis_pkg::S_READ:  state_nxt = dsis_pkg::S_RESP;
      dsis_pkg::S_RESP: begin
        if (resp_load) begin
          state_nxt = dsis_pkg::S_IDLE;
        end
      end
      default: state_nxt = dsis_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == dsis_pkg::S_IDLE);
    mod_start = (state_r == dsis_pkg::S_SETUP);
    resp_load = (state_r == dsis_pkg::S_RESP) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsis_pkg::S_IDLE;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        step_r <= 1'b0;
      end else if (state_r == dsis_pkg::S_APPLY) begin
        step_r <= ~step_r;
      end
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working coordinates and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      r_r   <= CW'(in_row);
      c_r   <= CW'(in_col);
      oor_r <= !in_inside;
    end else if (state_r == dsis_pkg::S_APPLY) begin
      r_r <= r_new;
      c_r <= c_new;
    end
    if (resp_load) begin
      out_data_r <= oor_r ? '0 : rd_data_r;
      out_oor_r  <= oor_r;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_pix & PIX_MASK;
    end
    if (state_r == dsis_pkg::S_READ) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

  `DSIS_ASSERT_IMPL(a_mod_start_idle, mod_start, !mod_stat.busy)
  `DSIS_ASSERT_IMPL(a_apply_after_done, state_r == dsis_pkg::S_APPLY, $past(mod_stat.done))
  `DSIS_ASSERT_IMPL(a_read_in_frame, state_r == dsis_pkg::S_READ,
                    (r_r < h_eff) && (c_r < w_eff))
  `DSIS_ASSERT_NEXT(a_read_starts_moves,
                    in_accept && (in_tuser == dsis_pkg::CMD_READ) && in_inside,
                    (state_r == dsis_pkg::S_SETUP) && !step_r)

endmodule

@@ src/dsis_mod_unit.sv @@
module dsis_mod_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dsis_pkg::DVD_W-1:0]    dividend,
  input  logic [dsis_pkg::COORD_W-1:0]  divisor,
  output dsis_pkg::mod_stat_t           stat,
  output logic [dsis_pkg::COORD_W-1:0]  rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [dsis_pkg::CNT_W-1:0]    cnt_r;
  logic [dsis_pkg::DVD_W-1:0]    dvd_r;
  logic [dsis_pkg::COORD_W-1:0]  dvs_r;
  logic [dsis_pkg::COORD_W-1:0]  rem_r;

  logic [dsis_pkg::COORD_W:0]    trial;
  logic [dsis_pkg::COORD_W:0]    diff;
  logic                          ge;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_r, dvd_r[dsis_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == dsis_pkg::CNT_W'(dsis_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[dsis_pkg::COORD_W-1:0] : trial[dsis_pkg::COORD_W-1:0];
      dvd_r <= {dvd_r[dsis_pkg::DVD_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

@@ verif/diagonal_shift_image_scrambler_unit_tb.sv @@
module diagonal_shift_image_scrambler_unit_tb;

  localparam int FRAME_ROWS   = 256;
  localparam int FRAME_COLS   = 256;
  localparam int READ_LATENCY = 28;
  localparam int IDLE_PCT     = 28;

  // one returned item: pixel plus the outside-frame flag
  typedef struct packed {
    logic [23:0] pixel;
    logic        oor;
  } pixel_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // row [7:0], col [15:8], pixel_in [39:16]
  logic        in_tuser   = 1'b0; // cmd [0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // pixel_out [23:0]
  logic        out_tuser;         // out_of_range [0]
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = dsis_pkg::REG_PERM_INDEX;
  logic [8:0]  cfg_wdata  = '0;

  // shadow copy of the register file, reset values
  logic [6:0] perm_sel   = 7'd0;
  logic       inverse_on = 1'b0;
  logic [8:0] rows_cfg   = 9'd256;
  logic [8:0] cols_cfg   = 9'd256;

  // shadow copy of the frame store and a map of entries written so far
  logic [23:0] pixel_mirror [FRAME_ROWS*FRAME_COLS];
  bit          written_mask [FRAME_ROWS*FRAME_COLS];

  // pixels the block owes us, oldest first
  pixel_result_t pending_pixels [$];
  int            fault_count = 0;
  // when set, neither side inserts bubbles
  bit            steady_flow = 1'b0;

  // move pair table: first move, second move
  dsis_pkg::move_t lead_move  [8] = '{dsis_pkg::MV_R, dsis_pkg::MV_R, dsis_pkg::MV_L,
                                      dsis_pkg::MV_L, dsis_pkg::MV_U, dsis_pkg::MV_U,
                                      dsis_pkg::MV_D, dsis_pkg::MV_D};
  dsis_pkg::move_t trail_move [8] = '{dsis_pkg::MV_D, dsis_pkg::MV_U, dsis_pkg::MV_D,
                                      dsis_pkg::MV_U, dsis_pkg::MV_R, dsis_pkg::MV_L,
                                      dsis_pkg::MV_R, dsis_pkg::MV_L};

  diagonal_shift_image_scrambler_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result side backpressure, ready low with a chance of about 28 in a hundred
  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // frame size after saturation to the store dimensions
  function automatic int rows_eff();
    return (rows_cfg > 9'd256) ? FRAME_ROWS : int'(rows_cfg);
  endfunction

  function automatic int cols_eff();
    return (cols_cfg > 9'd256) ? FRAME_COLS : int'(cols_cfg);
  endfunction

  function automatic bit in_frame(input int r, input int c);
    return (r < rows_eff()) && (c < cols_eff());
  endfunction

  // r <-> l, u <-> d
  function automatic dsis_pkg::move_t undo_move(input dsis_pkg::move_t m);
    case (m)
      dsis_pkg::MV_R: return dsis_pkg::MV_L;
      dsis_pkg::MV_L: return dsis_pkg::MV_R;
      dsis_pkg::MV_U: return dsis_pkg::MV_D;
      default:        return dsis_pkg::MV_U;
    endcase
  endfunction

  // map an output coordinate of one diagonal move back to where it came from
  function automatic void step_back(input dsis_pkg::move_t mv, input int h, input int w,
                                    inout int r, inout int c);
    int amt;
    int t;
    // horizontal moves shift by bits 1..0, vertical ones by bits 3..2
    amt = (mv == dsis_pkg::MV_R || mv == dsis_pkg::MV_L) ? int'(perm_sel[1:0])
                                                          : int'(perm_sel[3:2]);
    case (mv)
      dsis_pkg::MV_R: c = (c + r + amt) % w;
      dsis_pkg::MV_L: begin
        t = (r + amt) % w;
        c = (c + w - t) % w;
      end
      dsis_pkg::MV_U: r = (r + c + amt) % h;
      default: begin
        t = (c + amt) % h;
        r = (r + h - t) % h;
      end
    endcase
  endfunction

  // stored coordinate that a read at (r_out, c_out) of the scrambled image returns
  function automatic void source_pos(input int r_out, input int c_out,
                                     output int r_src, output int c_src);
    int              h;
    int              w;
    dsis_pkg::move_t m1;
    dsis_pkg::move_t m2;
    h     = rows_eff();
    w     = cols_eff();
    r_src = r_out;
    c_src = c_out;
    m1    = lead_move[perm_sel[6:4]];
    m2    = trail_move[perm_sel[6:4]];
    if (!inverse_on) begin
      // forward: the last move applied is peeled off first
      step_back(m2, h, w, r_src, c_src);
      step_back(m1, h, w, r_src, c_src);
    end else begin
      // inverse image is undo(second) then undo(first); peel undo(first) first
      step_back(undo_move(m1), h, w, r_src, c_src);
      step_back(undo_move(m2), h, w, r_src, c_src);
    end
  endfunction

  function automatic logic [8:0] pick_size();
    case ($urandom_range(9))
      0:       return 9'd1;
      1:       return 9'd256;
      2:       return 9'($urandom_range(257, 511));
      3:       return 9'd2;
      4, 5:    return 9'($urandom_range(1, 255));
      default: return 9'($urandom_range(1, 16));
    endcase
  endfunction

  // present one item, wait for the handshake, then update the shadow state
  task automatic send_item(input logic cmd, input logic [7:0] r, input logic [7:0] c,
                           input logic [23:0] pix);
    pixel_result_t want;
    int            sr;
    int            sc;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pix, c, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // item taken at this edge
    if (cmd == dsis_pkg::CMD_WRITE) begin
      // writes outside the frame are dropped by the block
      if (in_frame(int'(r), int'(c))) begin
        pixel_mirror[r*FRAME_COLS + c] = pix;
        written_mask[r*FRAME_COLS + c] = 1'b1;
      end
    end else if (!in_frame(int'(r), int'(c))) begin
      want.pixel = '0;
      want.oor   = 1'b1;
      pending_pixels.push_back(want);
    end else begin
      source_pos(int'(r), int'(c), sr, sc);
      want.pixel = pixel_mirror[sr*FRAME_COLS + sc];
      want.oor   = 1'b0;
      pending_pixels.push_back(want);
    end
  endtask

  // read the scrambled image, first filling the source entry if it was never stored
  task automatic read_pixel(input logic [7:0] r, input logic [7:0] c);
    int sr;
    int sc;
    if (in_frame(int'(r), int'(c))) begin
      source_pos(int'(r), int'(c), sr, sc);
      if (!written_mask[sr*FRAME_COLS + sc])
        send_item(dsis_pkg::CMD_WRITE, sr[7:0], sc[7:0], 24'($urandom()));
    end
    send_item(dsis_pkg::CMD_READ, r, c, 24'($urandom()));
  endtask

  // wait until every owed pixel has come back and the block has gone quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (READ_LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dsis_pkg::REG_PERM_INDEX:   perm_sel   = val[6:0];
      dsis_pkg::REG_INVERT_MODE:  inverse_on = val[0];
      dsis_pkg::REG_FRAME_HEIGHT: rows_cfg   = val;
      dsis_pkg::REG_FRAME_WIDTH:  cols_cfg   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [6:0] perm, input logic inv,
                               input logic [8:0] rows, input logic [8:0] cols);
    drain();
    write_reg(dsis_pkg::REG_PERM_INDEX, {2'b00, perm});
    write_reg(dsis_pkg::REG_INVERT_MODE, {8'd0, inv});
    write_reg(dsis_pkg::REG_FRAME_HEIGHT, rows);
    write_reg(dsis_pkg::REG_FRAME_WIDTH, cols);
  endtask

  // mostly well-formed reads inside the frame, plus writes and stray coordinates
  task automatic run_traffic(input int count);
    int h;
    int w;
    int pick;
    h = rows_eff();
    w = cols_eff();
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55 && h > 0 && w > 0)
        read_pixel(8'($urandom_range(h - 1)), 8'($urandom_range(w - 1)));
      else if (pick < 75 && h > 0 && w > 0)
        send_item(dsis_pkg::CMD_WRITE, 8'($urandom_range(h - 1)),
                  8'($urandom_range(w - 1)), 24'($urandom()));
      else if (pick < 88)
        read_pixel(8'($urandom()), 8'($urandom()));
      else
        send_item(dsis_pkg::CMD_WRITE, 8'($urandom()), 8'($urandom()), 24'($urandom()));
    end
  endtask

  // reset register values: pair r,d with no shift on a full 256x256 frame
  task automatic test_reset_values();
    send_item(dsis_pkg::CMD_WRITE, 8'd0,   8'd0,   24'h000000);
    send_item(dsis_pkg::CMD_WRITE, 8'd255, 8'd255, 24'hFFFFFF);
    send_item(dsis_pkg::CMD_WRITE, 8'd0,   8'd255, 24'hA5A5A5);
    send_item(dsis_pkg::CMD_WRITE, 8'd255, 8'd0,   24'h5A5A5A);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
    read_pixel(8'd0, 8'd255);
    read_pixel(8'd255, 8'd0);
  endtask

  // oversized frame saturates, zero-size frame rejects everything, tiny frame edges
  task automatic test_frame_edges();
    apply_setting(7'd127, 1'b1, 9'd511, 9'd300);
    read_pixel(8'd255, 8'd255);
    read_pixel(8'd0, 8'd0);
    apply_setting(7'h35, 1'b0, 9'd0, 9'd256);
    send_item(dsis_pkg::CMD_WRITE, 8'd0, 8'd0, 24'h123456);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
    apply_setting(7'h4F, 1'b1, 9'd3, 9'd1);
    send_item(dsis_pkg::CMD_WRITE, 8'd5, 8'd5, 24'hFFFFFF);
    send_item(dsis_pkg::CMD_WRITE, 8'd2, 8'd0, 24'hC3C3C3);
    read_pixel(8'd2, 8'd0);
    read_pixel(8'd3, 8'd0);
    read_pixel(8'd0, 8'd1);
  endtask

  // every move pair in both directions with random shifts and frame sizes
  task automatic test_move_pairs();
    for (int pair = 0; pair < 8; pair++) begin
      for (int inv = 0; inv < 2; inv++) begin
        apply_setting({3'(pair), 4'($urandom_range(15))}, 1'(inv), pick_size(), pick_size());
        run_traffic(30);
      end
    end
  endtask

  // fully random settings, starting with the two index extremes
  task automatic test_random_settings();
    apply_setting(7'd0, 1'b0, 9'd256, 9'd256);
    run_traffic(40);
    apply_setting(7'd127, 1'b1, 9'd1, 9'd256);
    run_traffic(40);
    repeat (10) begin
      apply_setting(7'($urandom_range(127)), 1'($urandom_range(1)), pick_size(), pick_size());
      run_traffic(40);
    end
  endtask

  // no bubbles on either side: writes stream back to back, reads follow
  task automatic test_back_to_back();
    apply_setting(7'($urandom_range(127)), 1'($urandom_range(1)), 9'd16, 9'd16);
    steady_flow = 1'b1;
    repeat (40)
      send_item(dsis_pkg::CMD_WRITE, 8'($urandom_range(15)), 8'($urandom_range(15)),
                24'($urandom()));
    repeat (30) read_pixel(8'($urandom_range(17)), 8'($urandom_range(17)));
    drain();
    steady_flow = 1'b0;
  endtask

  // compare every returned item with the oldest owed pixel
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected item: pixel %h oor %b", out_tdata, out_tuser);
        fault_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want.pixel) begin
          if (fault_count < 10)
            $display("pixel mismatch: expected %h got %h", want.pixel, out_tdata);
          fault_count++;
        end
        if (out_tuser !== want.oor) begin
          if (fault_count < 10)
            $display("out_of_range mismatch: expected %b got %b", want.oor, out_tuser);
          fault_count++;
        end
      end
    end
  end

  initial begin
    // synchronous reset held, then released
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_frame_edges();
    test_move_pairs();
    test_random_settings();
    test_back_to_back();
    drain();
    // anything still owed counts against the run
    if (pending_pixels.size() != 0) fault_count++;
    if (fault_count == 0)
      $display("diagonal_shift_image_scrambler_unit test passed");
    else
      $display("diagonal_shift_image_scrambler_unit test failed");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("diagonal_shift_image_scrambler_unit test failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/dsis_pkg.sv
src/dsis_mod_unit.sv
src/diagonal_shift_image_scrambler_unit.sv
verif/diagonal_shift_image_scrambler_unit_tb.sv
